FILE: rtl/vri_pkg.sv
`default_nettype none

package vri_pkg;

  // Storage sizes
  localparam int SPRITE_MEM_DEPTH = 256;
  localparam int PALETTE_DEPTH    = 32;
  localparam int SPR_AW           = $clog2(SPRITE_MEM_DEPTH);
  localparam int PAL_AW           = $clog2(PALETTE_DEPTH);

  // Event kinds
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // External bus request codes
  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_READ  = 2'd1;
  localparam logic [1:0] BUS_WRITE = 2'd2;

  // Sprite memory access
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [SPR_AW-1:0] addr;
    logic [7:0]        wdata;
  } spr_req_t;

  // Palette memory access
  typedef struct packed {
    logic              wr;
    logic [PAL_AW-1:0] index;
    logic [7:0]        wdata;
  } pal_req_t;

  // Palette entry for a data-port address; backdrop entries of the upper
  // half alias those of the lower half
  function automatic logic [PAL_AW-1:0] pal_slot(input logic [13:0] a);
    logic [4:0] i;
    i = a[4:0];
    if ((i & 5'h13) == 5'h10) begin
      i = i & 5'h0F;
    end
    return i[PAL_AW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/video_register_interface.sv
// Processor-side register file of a tile video processor.
// Input channel s_axis: one event per transfer; tuser carries the event kind
// and register number, tdata the written byte, the captured bus byte and
// the status flag bits for set/clear events.
// Output channel m_axis: one result per event, holding the open-bus byte,
// any external memory request (kind, 14-bit address, write byte), the
// interrupt line and the control, mask, scroll and fine X state after it.
// Latency: the result is valid in the cycle after the input transfer.
// Throughput: one event per cycle while the result is not held; all state
// updates happen on the input transfer, sprite memory reads come from a
// registered port and feed the next event by forwarding.
// The output register stalls the input only while its result is held:
// s_axis_tready is low when m_axis_tvalid is high and m_axis_tready is low.
// Reset clears the state registers, the palette and the sprite memory marks,
// not the bus request fields; the block takes events once reset is released.
`default_nettype none

module video_register_interface
  import vri_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // write_data [7:0], bus_data [15:8], flag_bits [18:16], zero pad
  input  wire logic [23:0] s_axis_tdata,
  // op [1:0], reg_index [4:2]
  input  wire logic [4:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data [7:0], bus_request [9:8], bus_address [23:10],
  // bus_write_value [31:24], nmi_out [32], control_value [40:33],
  // mask_value [48:41], current_scroll [63:49], temp_scroll [78:64],
  // fine_x_out [81:79], zero pad
  output logic [87:0]      m_axis_tdata
);

  // Input fields
  logic [1:0] op;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] bus_data;
  logic [2:0] flag_bits;
  logic       accept;

  assign op         = s_axis_tuser[1:0];
  assign reg_index  = s_axis_tuser[4:2];
  assign write_data = s_axis_tdata[7:0];
  assign bus_data   = s_axis_tdata[15:8];
  assign flag_bits  = s_axis_tdata[18:16];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Architectural state
  logic [7:0]        control_reg, control_reg_next;
  logic [7:0]        mask_reg, mask_reg_next;
  logic [2:0]        status_flags, status_flags_next;
  logic              write_toggle, write_toggle_next;
  logic [7:0]        last_value, last_value_next;
  logic              last_from_sprite, last_from_sprite_next;
  logic [14:0]       current_addr, current_addr_next;
  logic [14:0]       temporary_addr, temporary_addr_next;
  logic [2:0]        fine_x, fine_x_next;
  logic [SPR_AW-1:0] sprite_mem_addr, sprite_mem_addr_next;

  // Result register
  logic [1:0]  bus_request, bus_request_next;
  logic [13:0] bus_address, bus_address_next;
  logic [7:0]  bus_write_value, bus_write_value_next;

  spr_req_t   spr_req;
  pal_req_t   pal_req;
  logic [7:0] spr_rdata;
  logic [7:0] pal_rdata;

  vri_sprite_mem u_sprite_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (spr_req),
    .rdata (spr_rdata)
  );

  vri_palette u_palette (
    .clk   (clk),
    .rst   (rst),
    .req   (pal_req),
    .rdata (pal_rdata)
  );

  // Open-bus byte, forwarded from sprite memory after a sprite data read
  logic [7:0]  open_bus;
  logic [13:0] data_addr;
  logic        data_is_pal;
  logic [13:0] data_addr_stepped;

  assign open_bus          = last_from_sprite ? spr_rdata : last_value;
  assign data_addr         = current_addr[13:0];
  assign data_is_pal       = (data_addr[13:8] == 6'h3F);
  assign data_addr_stepped = data_addr + (control_reg[2] ? 14'd32 : 14'd1);

  // Event decode
  always_comb begin
    control_reg_next      = control_reg;
    mask_reg_next         = mask_reg;
    status_flags_next     = status_flags;
    write_toggle_next     = write_toggle;
    last_value_next       = open_bus;
    last_from_sprite_next = 1'b0;
    current_addr_next     = current_addr;
    temporary_addr_next   = temporary_addr;
    fine_x_next           = fine_x;
    sprite_mem_addr_next  = sprite_mem_addr;
    bus_request_next      = BUS_NONE;
    bus_address_next      = 14'd0;
    bus_write_value_next  = 8'h00;
    spr_req.wr            = 1'b0;
    spr_req.rd            = 1'b0;
    spr_req.addr          = sprite_mem_addr;
    spr_req.wdata         = write_data;
    pal_req.wr            = 1'b0;
    pal_req.index         = pal_slot(data_addr);
    pal_req.wdata         = write_data;

    unique case (op)
      OP_SET: begin
        status_flags_next = status_flags | flag_bits;
      end
      OP_CLEAR: begin
        status_flags_next = status_flags & ~flag_bits;
      end
      OP_WRITE: begin
        last_value_next = write_data;
        unique case (reg_index)
          REG_CTRL: begin
            control_reg_next            = write_data;
            temporary_addr_next[11:10]  = write_data[1:0];
          end
          REG_MASK: begin
            mask_reg_next = write_data;
          end
          REG_OAM_ADDR: begin
            sprite_mem_addr_next = write_data[SPR_AW-1:0];
          end
          REG_OAM_DATA: begin
            spr_req.wr           = accept;
            sprite_mem_addr_next = sprite_mem_addr + SPR_AW'(1);
          end
          REG_SCROLL: begin
            if (!write_toggle) begin
              fine_x_next              = write_data[2:0];
              temporary_addr_next[4:0] = write_data[7:3];
            end else begin
              temporary_addr_next[14:12] = write_data[2:0];
              temporary_addr_next[9:5]   = write_data[7:3];
            end
            write_toggle_next = !write_toggle;
          end
          REG_ADDR: begin
            if (!write_toggle) begin
              temporary_addr_next = {1'b0, write_data[5:0], temporary_addr[7:0]};
            end else begin
              temporary_addr_next = {temporary_addr[14:8], write_data};
              current_addr_next   = {temporary_addr[14:8], write_data};
            end
            write_toggle_next = !write_toggle;
          end
          REG_DATA: begin
            if (data_is_pal) begin
              pal_req.wr = accept;
            end else begin
              bus_request_next     = BUS_WRITE;
              bus_address_next     = data_addr;
              bus_write_value_next = write_data;
            end
            current_addr_next = {current_addr[14], data_addr_stepped};
          end
          default: begin
          end
        endcase
      end
      default: begin
        // register read
        unique case (reg_index)
          REG_STATUS: begin
            last_value_next   = {status_flags, open_bus[4:0]};
            status_flags_next = {1'b0, status_flags[1:0]};
            write_toggle_next = 1'b0;
          end
          REG_OAM_DATA: begin
            spr_req.rd            = accept;
            last_from_sprite_next = 1'b1;
          end
          REG_DATA: begin
            if (data_is_pal) begin
              last_value_next = pal_rdata & (mask_reg[0] ? 8'h30 : 8'hFF);
            end else begin
              bus_request_next = BUS_READ;
              bus_address_next = data_addr;
              last_value_next  = bus_data;
            end
            current_addr_next = {current_addr[14], data_addr_stepped};
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  // State and result update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg      <= 8'h00;
      mask_reg         <= 8'h00;
      status_flags     <= 3'b000;
      write_toggle     <= 1'b0;
      last_value       <= 8'h00;
      last_from_sprite <= 1'b0;
      current_addr     <= 15'd0;
      temporary_addr   <= 15'd0;
      fine_x           <= 3'd0;
      sprite_mem_addr  <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        control_reg      <= control_reg_next;
        mask_reg         <= mask_reg_next;
        status_flags     <= status_flags_next;
        write_toggle     <= write_toggle_next;
        last_value       <= last_value_next;
        last_from_sprite <= last_from_sprite_next;
        current_addr     <= current_addr_next;
        temporary_addr   <= temporary_addr_next;
        fine_x           <= fine_x_next;
        sprite_mem_addr  <= sprite_mem_addr_next;
        m_axis_tvalid    <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Bus request fields of the held result
  always_ff @(posedge clk) begin
    if (accept) begin
      bus_request     <= bus_request_next;
      bus_address     <= bus_address_next;
      bus_write_value <= bus_write_value_next;
    end
  end

  // Result packing; state fields reflect the last accepted event
  logic nmi;
  assign nmi = status_flags[2] && control_reg[7];

  assign m_axis_tdata = {6'd0, fine_x, temporary_addr, current_addr, mask_reg,
                         control_reg, nmi, bus_write_value, bus_address,
                         bus_request, open_bus};

  // Checks
  a_status_read_clears : assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_READ && reg_index == REG_STATUS
    |=> !status_flags[2] && !write_toggle)
    else $error("status read did not clear vblank and toggle");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("no result after transfer");

  a_bus_code : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (bus_request == BUS_NONE || bus_request == BUS_READ ||
                       bus_request == BUS_WRITE))
    else $error("illegal bus request code");

  a_data_step_keeps_top : assert property (@(posedge clk) disable iff (rst)
    accept && reg_index == REG_DATA && (op == OP_READ || op == OP_WRITE)
    |=> current_addr[14] == $past(current_addr[14]))
    else $error("data port step changed address bit 14");

endmodule

`default_nettype wire

FILE: rtl/vri_sprite_mem.sv
`default_nettype none

module vri_sprite_mem
  import vri_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire spr_req_t   req,
  output logic [7:0]      rdata
);

  logic [7:0]                  mem [SPRITE_MEM_DEPTH];
  logic [SPRITE_MEM_DEPTH-1:0] valid;
  logic [7:0]                  rdata_q;
  logic                        valid_q;

  // Storage array, registered read port
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_q <= mem[req.addr];
    end
  end

  // Written-entry marks; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (req.wr) begin
        valid[req.addr] <= 1'b1;
      end
      if (req.rd) begin
        valid_q <= valid[req.addr];
      end
    end
  end

  assign rdata = valid_q ? rdata_q : 8'h00;

endmodule

`default_nettype wire

FILE: rtl/vri_palette.sv
`default_nettype none

module vri_palette
  import vri_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire pal_req_t   req,
  output logic [7:0]      rdata
);

  logic [7:0] entries [PALETTE_DEPTH];

  // Small register file, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        entries[i] <= 8'h00;
      end
    end else if (req.wr) begin
      entries[req.index] <= req.wdata;
    end
  end

  assign rdata = entries[req.index];

endmodule

`default_nettype wire
